// ----- src/thermistor_adc_to_celsius_assert.svh -----
// assertion macros for the thermistor converter
// expects i_clk and i_rst_n in the scope of use
`ifndef THERMISTOR_ADC_TO_CELSIUS_ASSERT_SVH
`define THERMISTOR_ADC_TO_CELSIUS_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TAC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define TAC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tac_pkg.sv -----
// shared types, constants and the log table of the thermistor converter
// no dependencies
package tac_pkg;

    localparam int ADC_BITS_DEF = 12;
    localparam int ADC_W        = 12;
    localparam int DIV_W        = 20;
    localparam int CAL_W        = 18;
    localparam int IDX_W        = 2;
    localparam int RQ_W         = 42;
    localparam int R_W          = 41;
    localparam int Y_W          = 36;
    localparam int YD_W         = 35;
    localparam int TK_W         = 47;
    localparam int TEMP_W       = 16;

    localparam logic [IDX_W-1:0] REG_DIVIDER = 2'd0;
    localparam logic [IDX_W-1:0] REG_CAL     = 2'd1;

    localparam logic [DIV_W-1:0] DIVIDER_RST = 20'd10000;

    localparam logic signed [31:0] LN2Q = 32'sd11629080;
    localparam logic [30:0] AQ = 31'd1241511355;
    localparam logic [27:0] BQ = 28'd257423160;
    localparam logic [24:0] CQ = 25'd24678065;

    localparam logic [TK_W-1:0] TK_MAX    = 47'd60082;
    localparam logic [16:0]     KELVIN_C  = 17'd27315;
    localparam logic [TEMP_W-1:0] TEMP_HI = 16'h7FFF;
    localparam logic [TEMP_W-1:0] TEMP_LO = 16'h954D;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_NONPOS = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        Y_POS  = 2'd0,
        Y_ZERO = 2'd1,
        Y_NEG  = 2'd2
    } t_yclass;

    typedef struct packed {
        t_status status;
        t_yclass ycls;
    } t_side;

    // ln(1 + i/16) in q.24
    function automatic logic [23:0] ln_tab(input logic [4:0] idx);
        logic [23:0] v;
        case (idx)
            5'd0:    v = 24'd0;
            5'd1:    v = 24'd1017112;
            5'd2:    v = 24'd1976071;
            5'd3:    v = 24'd2883169;
            5'd4:    v = 24'd3743728;
            5'd5:    v = 24'd4562291;
            5'd6:    v = 24'd5342767;
            5'd7:    v = 24'd6088544;
            5'd8:    v = 24'd6802576;
            5'd9:    v = 24'd7487455;
            5'd10:   v = 24'd8145469;
            5'd11:   v = 24'd8778647;
            5'd12:   v = 24'd9388795;
            5'd13:   v = 24'd9977530;
            5'd14:   v = 24'd10546303;
            5'd15:   v = 24'd11096761;
            5'd16:   v = 24'd11629080;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/thermistor_adc_to_celsius.sv -----
// thermistor adc sample to temperature in hundredths of a degree celsius
// depends on tac_pkg, tac_div_chain, tac_log_poly and the assert macro header
//
// channel  | dir | tdata                      | tuser       | notes
// i_s_*    | in  | [11:0] adc_sample          | -           | one sample per transfer
// o_m_*    | out | [15:0] temp_centi_c        | [1:0] status| one result per sample
// i_cfg_*  | in  | [19:0] register value      | -           | idx 0 divider, 1 offset
//
// one sample accepted every cycle while the output is not stalled
// the two quotient chains set the depth: one cell per quotient bit
// a stalled output freezes the whole pipeline, so o_s_tready is low only while a held result waits on i_m_tready
// synchronous active-low reset clears the valid bits and sets the config registers to their defaults
`include "thermistor_adc_to_celsius_assert.svh"
module thermistor_adc_to_celsius #(
    parameter int ADC_BITS = tac_pkg::ADC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [15:0]               i_s_tdata,   // [11:0] adc_sample
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [15:0]               o_m_tdata,   // [15:0] temp_centi_c
    output logic [1:0]                o_m_tuser,   // [1:0] status
    input  logic                      i_cfg_we,
    input  logic [tac_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [tac_pkg::DIV_W-1:0] i_cfg_data
);
    import tac_pkg::*;

    localparam int NUM_W = DIV_W + ADC_BITS + 8;
    localparam logic [ADC_W-1:0] FULL12 = ADC_W'((1 << ADC_BITS) - 1);
    localparam logic [ADC_BITS-1:0] FULL_A = ADC_BITS'((1 << ADC_BITS) - 1);

    logic                      en;
    logic [DIV_W-1:0]          r_divider;
    logic signed [CAL_W-1:0]   r_cal;

    logic [ADC_W-1:0]          adc;
    logic [ADC_BITS-1:0]       adc_a;
    logic                      r0_vld;
    logic                      r0_err;
    logic [NUM_W-1:0]          r0_num;
    logic [ADC_BITS-1:0]       r0_den;
    logic                      n0_err;

    logic                      c1_vld;
    logic [NUM_W-1:0]          c1_quo;
    logic [0:0]                c1_err;

    logic signed [RQ_W-1:0]    rq;
    logic                      r1_vld;
    t_status                   r1_st;
    logic [R_W-1:0]            r1_r;
    t_status                   n1_st;

    logic                      p_vld;
    t_status                   p_st;
    logic signed [Y_W-1:0]     p_y;

    logic                      r2_vld;
    logic [TK_W-1:0]           r2_num;
    logic [YD_W-1:0]           r2_den;
    t_side                     r2_side;
    t_side                     n2_side;

    logic                      c2_vld;
    logic [TK_W-1:0]           c2_quo;
    logic [$bits(t_side)-1:0]  c2_side_v;
    t_side                     c2_side;

    logic                      r_out_vld;
    logic [TEMP_W-1:0]         r_temp;
    t_status                   r_status;
    logic [TEMP_W-1:0]         n_temp;

    assign en         = !r_out_vld || i_m_tready;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divider <= DIVIDER_RST;
            r_cal     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DIVIDER: r_divider <= i_cfg_data;
                REG_CAL:     r_cal     <= $signed(i_cfg_data[CAL_W-1:0]);
                default:     ;
            endcase
        end
    end

    // input stage: range check and the numerator product
    assign adc    = i_s_tdata[ADC_W-1:0];
    assign adc_a  = adc[ADC_BITS-1:0];
    assign n0_err = (adc == '0) || (adc >= FULL12);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_err <= n0_err;
            r0_num <= {(NUM_W-8)'(r_divider * adc_a), 8'd0};
            r0_den <= FULL_A - adc_a;
        end
    end

    tac_div_chain #(
        .DW (ADC_BITS),
        .NW (NUM_W),
        .SW (1)
    ) u_res_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r0_vld),
        .i_den   (r0_den),
        .i_num   (r0_num),
        .i_side  (r0_err),
        .o_valid (c1_vld),
        .o_quo   (c1_quo),
        .o_side  (c1_err)
    );

    // resistance plus offset, q.8
    assign rq = $signed(RQ_W'(c1_quo)) + (RQ_W'(r_cal) <<< 8);

    always_comb begin
        if (c1_err[0]) begin
            n1_st = ST_RANGE;
        end else if (rq[RQ_W-1] || (rq == '0)) begin
            n1_st = ST_NONPOS;
        end else begin
            n1_st = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= c1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_st <= n1_st;
            r1_r  <= rq[R_W-1:0];
        end
    end

    tac_log_poly u_poly (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r1_vld),
        .i_status (r1_st),
        .i_r      (r1_r),
        .o_valid  (p_vld),
        .o_status (p_st),
        .o_y      (p_y)
    );

    // reciprocal setup
    always_comb begin
        n2_side.status = p_st;
        if (p_y == '0) begin
            n2_side.ycls = Y_ZERO;
        end else if (p_y[Y_W-1]) begin
            n2_side.ycls = Y_NEG;
        end else begin
            n2_side.ycls = Y_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_side <= n2_side;
            r2_num  <= (TK_W'(100) << 40) + TK_W'(p_y[YD_W-1:1]);
            r2_den  <= p_y[YD_W-1:0];
        end
    end

    tac_div_chain #(
        .DW (YD_W),
        .NW (TK_W),
        .SW ($bits(t_side))
    ) u_inv_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_vld),
        .i_den   (r2_den),
        .i_num   (r2_num),
        .i_side  (r2_side),
        .o_valid (c2_vld),
        .o_quo   (c2_quo),
        .o_side  (c2_side_v)
    );

    assign c2_side = t_side'(c2_side_v);

    always_comb begin
        if (c2_side.status != ST_OK) begin
            n_temp = '0;
        end else begin
            case (c2_side.ycls)
                Y_ZERO:  n_temp = TEMP_HI;
                Y_NEG:   n_temp = TEMP_LO;
                default: begin
                    if (c2_quo > TK_MAX) begin
                        n_temp = TEMP_HI;
                    end else begin
                        n_temp = TEMP_W'(17'(c2_quo[15:0]) - KELVIN_C);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= c2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_temp   <= n_temp;
            r_status <= c2_side.status;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_temp;
    assign o_m_tuser  = r_status;

    `TAC_ASSERT_IMP(a_err_zero, o_m_tvalid && (o_m_tuser != ST_OK), o_m_tdata == '0, "error result carries a temperature")
    `TAC_ASSERT_IMP(a_status_code, o_m_tvalid, (o_m_tuser == ST_OK) || (o_m_tuser == ST_RANGE) || (o_m_tuser == ST_NONPOS), "bad status code")
    `TAC_ASSERT_IMP(a_temp_floor, o_m_tvalid && (o_m_tuser == ST_OK), $signed(o_m_tdata) >= -16'sd27315, "temperature below absolute zero")
    `TAC_ASSERT_NXT(a_stall_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(r_temp), "stalled result lost")

endmodule

// ----- src/tac_div_cell.sv -----
// one restoring division step: shifts in one numerator bit, emits one quotient bit
// does not use tac_pkg, no imports needed
module tac_div_cell #(
    parameter int DW = 12,
    parameter int NW = 40,
    parameter int SW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DW-1:0]     i_den,
    input  logic [DW+NW-1:0]  i_acc,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [DW-1:0]     o_den,
    output logic [DW+NW-1:0]  o_acc,
    output logic [SW-1:0]     o_side
);

    logic              r_valid;
    logic [DW-1:0]     r_den;
    logic [DW+NW-1:0]  r_acc;
    logic [SW-1:0]     r_side;
    logic [DW:0]       top;
    logic [DW:0]       diff;
    logic [DW+NW-1:0]  n_acc;

    always_comb begin
        top  = i_acc[DW+NW-1:NW-1];
        diff = top - {1'b0, i_den};
        if (top >= {1'b0, i_den}) begin
            n_acc = {diff[DW-1:0], i_acc[NW-2:0], 1'b1};
        end else begin
            n_acc = {top[DW-1:0], i_acc[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den  <= i_den;
            r_acc  <= n_acc;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_den   = r_den;
    assign o_acc   = r_acc;
    assign o_side  = r_side;

endmodule

// ----- src/tac_div_chain.sv -----
// row of NW division cells, one quotient bit per cell
// depends on tac_div_cell
module tac_div_chain #(
    parameter int DW = 12,
    parameter int NW = 40,
    parameter int SW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DW-1:0]     i_den,
    input  logic [NW-1:0]     i_num,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [NW-1:0]     o_quo,
    output logic [SW-1:0]     o_side
);

    logic              vld  [0:NW];
    logic [DW-1:0]     den  [0:NW];
    logic [DW+NW-1:0]  acc  [0:NW];
    logic [SW-1:0]     side [0:NW];

    assign vld[0]  = i_valid;
    assign den[0]  = i_den;
    assign acc[0]  = {{DW{1'b0}}, i_num};
    assign side[0] = i_side;

    for (genvar k = 0; k < NW; k++) begin : g_cell
        tac_div_cell #(
            .DW (DW),
            .NW (NW),
            .SW (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (vld[k]),
            .i_den   (den[k]),
            .i_acc   (acc[k]),
            .i_side  (side[k]),
            .o_valid (vld[k+1]),
            .o_den   (den[k+1]),
            .o_acc   (acc[k+1]),
            .o_side  (side[k+1])
        );
    end

    assign o_valid = vld[NW];
    assign o_quo   = acc[NW][NW-1:0];
    assign o_side  = side[NW];

endmodule

// ----- src/tac_log_poly.sv -----
// log by table and interpolation, then the steinhart-hart cubic, nine stages
// depends on tac_pkg
module tac_log_poly (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  tac_pkg::t_status        i_status,
    input  logic [tac_pkg::R_W-1:0] i_r,
    output logic                    o_valid,
    output tac_pkg::t_status        o_status,
    output logic signed [tac_pkg::Y_W-1:0] o_y
);
    import tac_pkg::*;

    localparam int NSTG = 9;

    logic        r_vld [1:NSTG];
    t_status     r_st  [1:NSTG];

    logic [5:0]         r1_p;
    logic [R_W-1:0]     r1_r;
    logic [5:0]         r2_p;
    logic [3:0]         r2_i;
    logic [23:0]        r2_t;
    logic signed [30:0] r3_base;
    logic [43:0]        r3_prod;
    logic signed [30:0] r4_l;
    logic [28:0]        r5_m;
    logic               r5_neg;
    logic [57:0]        r6_sq;
    logic [56:0]        r6_bp;
    logic [28:0]        r6_m;
    logic               r6_neg;
    logic [62:0]        r7_cub;
    logic [32:0]        r7_bl;
    logic               r7_neg;
    logic [43:0]        r8_plo;
    logic [44:0]        r8_phi;
    logic [32:0]        r8_bl;
    logic               r8_neg;
    logic signed [Y_W-1:0] r9_y;

    logic [5:0]         n1_p;
    logic [R_W-1:0]     n2_u;
    logic [23:0]        tab_lo;
    logic [23:0]        tab_hi;
    logic [19:0]        tab_d;
    logic signed [6:0]  pm8;
    logic signed [31:0] n3_base;
    logic [43:0]        n3_prod;
    logic signed [30:0] n4_l;
    logic signed [30:0] abs_l;
    logic [57:0]        n6_sq;
    logic [56:0]        n6_bp;
    logic [33:0]        m2;
    logic [62:0]        n7_cub;
    logic [38:0]        m3;
    logic [43:0]        n8_plo;
    logic [44:0]        n8_phi;
    logic [63:0]        csum;
    logic [31:0]        cl;
    logic signed [Y_W-1:0] n9_y;

    always_comb begin
        n1_p = '0;
        for (int b = 0; b < R_W; b++) begin
            if (i_r[b]) begin
                n1_p = 6'(b);
            end
        end
    end

    assign n2_u = r1_r << (6'd40 - r1_p);

    always_comb begin
        tab_lo  = ln_tab({1'b0, r2_i});
        tab_hi  = ln_tab(5'({1'b0, r2_i}) + 5'd1);
        tab_d   = 20'(tab_hi - tab_lo);
        pm8     = $signed({1'b0, r2_p}) - 7'sd8;
        n3_base = 32'(pm8) * LN2Q + $signed({8'd0, tab_lo});
        n3_prod = tab_d * r2_t;
    end

    assign n4_l  = r3_base + $signed({11'd0, r3_prod[43:24]});
    assign abs_l = r4_l[30] ? -r4_l : r4_l;

    assign n6_sq  = r5_m * r5_m;
    assign n6_bp  = BQ * r5_m;
    assign m2     = r6_sq[57:24];
    assign n7_cub = m2 * r6_m;
    assign m3     = r7_cub[62:24];
    assign n8_plo = CQ * m3[18:0];
    assign n8_phi = CQ * m3[38:19];
    assign csum   = {r8_phi, 19'd0} + 64'(r8_plo);
    assign cl     = csum[63:32];

    always_comb begin
        if (r8_neg) begin
            n9_y = $signed(Y_W'(AQ)) - $signed(Y_W'(r8_bl)) - $signed(Y_W'(cl));
        end else begin
            n9_y = $signed(Y_W'(AQ)) + $signed(Y_W'(r8_bl)) + $signed(Y_W'(cl));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= NSTG; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[1] <= i_valid;
            for (int s = 2; s <= NSTG; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[1] <= i_status;
            for (int s = 2; s <= NSTG; s++) begin
                r_st[s] <= r_st[s-1];
            end
            r1_p    <= n1_p;
            r1_r    <= i_r;
            r2_p    <= r1_p;
            r2_i    <= n2_u[39:36];
            r2_t    <= n2_u[35:12];
            r3_base <= n3_base[30:0];
            r3_prod <= n3_prod;
            r4_l    <= n4_l;
            r5_m    <= abs_l[28:0];
            r5_neg  <= r4_l[30];
            r6_sq   <= n6_sq;
            r6_bp   <= n6_bp;
            r6_m    <= r5_m;
            r6_neg  <= r5_neg;
            r7_cub  <= n7_cub;
            r7_bl   <= r6_bp[56:24];
            r7_neg  <= r6_neg;
            r8_plo  <= n8_plo;
            r8_phi  <= n8_phi;
            r8_bl   <= r7_bl;
            r8_neg  <= r7_neg;
            r9_y    <= n9_y;
        end
    end

    assign o_valid  = r_vld[NSTG];
    assign o_status = r_st[NSTG];
    assign o_y      = r9_y;

endmodule
